// File: hw/rtl/tfn_pkg.sv
// shared types and constants of the triangle face normal pipeline
package tfn_pkg;

	localparam int CoordW = 24;
	localparam int EdgeW  = 25;
	localparam int ProdW  = 50;
	localparam int MagW   = 49;
	localparam int NormW  = 30;
	localparam int RootW  = 31;
	localparam int QuotW  = 15;
	localparam int OutW   = 16;

	// one triangle item
	typedef struct packed {
		logic signed [CoordW-1:0] ax;
		logic signed [CoordW-1:0] ay;
		logic signed [CoordW-1:0] az;
		logic signed [CoordW-1:0] bx;
		logic signed [CoordW-1:0] by_coord;
		logic signed [CoordW-1:0] bz;
		logic signed [CoordW-1:0] cx;
		logic signed [CoordW-1:0] cy;
		logic signed [CoordW-1:0] cz;
		logic                     last_in;
	} tfn_tri_t;

	// one normal item
	typedef struct packed {
		logic signed [OutW-1:0] nx;
		logic signed [OutW-1:0] ny;
		logic signed [OutW-1:0] nz;
		logic                   degenerate;
		logic                   last_out;
	} tfn_nrm_t;

	// cross product magnitudes and signs
	typedef struct packed {
		logic [2:0][MagW-1:0] m;
		logic [2:0]           neg;
		logic                 last;
	} tfn_mag_t;

	// normalised magnitudes travelling beside the root and divider
	typedef struct packed {
		logic [2:0][NormW-1:0] m;
		logic [2:0]            neg;
		logic                  degen;
		logic                  last;
	} tfn_side_t;

endpackage

// File: hw/rtl/tfn_if.sv
// valid/ready channel carrying one item
interface tfn_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tfn_cross.sv
// edge vectors, split cross product and magnitude extraction
module tfn_cross (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               v_in,
	input  tfn_pkg::tfn_tri_t  tri_in,
	output logic               v_out,
	output tfn_pkg::tfn_mag_t  mag_out
);

	logic signed [tfn_pkg::EdgeW-1:0] e1_s1 [3];
	logic signed [tfn_pkg::EdgeW-1:0] e2_s1 [3];
	logic                             last_s1, last_s2, last_s3, last_s4;
	logic                             v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [23:0] hh_s2 [6];
	logic signed [25:0] hl_s2 [6];
	logic signed [25:0] lh_s2 [6];
	logic        [25:0] ll_s2 [6];
	logic signed [tfn_pkg::ProdW-1:0] p_s3 [6];
	logic signed [tfn_pkg::ProdW-1:0] n_s4 [3];
	tfn_pkg::tfn_mag_t mag_s5;

	logic signed [tfn_pkg::EdgeW-1:0] opa [6];
	logic signed [tfn_pkg::EdgeW-1:0] opb [6];

	// operand pairs of the six products
	always_comb begin
		opa[0] = e1_s1[1]; opb[0] = e2_s1[2];
		opa[1] = e1_s1[2]; opb[1] = e2_s1[1];
		opa[2] = e1_s1[2]; opb[2] = e2_s1[0];
		opa[3] = e1_s1[0]; opb[3] = e2_s1[2];
		opa[4] = e1_s1[0]; opb[4] = e2_s1[1];
		opa[5] = e1_s1[1]; opb[5] = e2_s1[0];
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// edges
			e1_s1[0] <= $signed({tri_in.bx[23], tri_in.bx}) - $signed({tri_in.ax[23], tri_in.ax});
			e1_s1[1] <= $signed({tri_in.by_coord[23], tri_in.by_coord})
				- $signed({tri_in.ay[23], tri_in.ay});
			e1_s1[2] <= $signed({tri_in.bz[23], tri_in.bz}) - $signed({tri_in.az[23], tri_in.az});
			e2_s1[0] <= $signed({tri_in.cx[23], tri_in.cx}) - $signed({tri_in.ax[23], tri_in.ax});
			e2_s1[1] <= $signed({tri_in.cy[23], tri_in.cy}) - $signed({tri_in.ay[23], tri_in.ay});
			e2_s1[2] <= $signed({tri_in.cz[23], tri_in.cz}) - $signed({tri_in.az[23], tri_in.az});
			last_s1 <= tri_in.last_in;
			// partial products, high part signed 12 bits, low part unsigned 13 bits
			for (int k = 0; k < 6; k++) begin
				hh_s2[k] <= $signed(opa[k][24:13]) * $signed(opb[k][24:13]);
				hl_s2[k] <= $signed(opa[k][24:13]) * $signed({1'b0, opb[k][12:0]});
				lh_s2[k] <= $signed({1'b0, opa[k][12:0]}) * $signed(opb[k][24:13]);
				ll_s2[k] <= opa[k][12:0] * opb[k][12:0];
			end
			last_s2 <= last_s1;
			// recombine partial products
			for (int k = 0; k < 6; k++) begin
				p_s3[k] <= (50'(hh_s2[k]) <<< 26) + (50'(hl_s2[k]) <<< 13)
					+ (50'(lh_s2[k]) <<< 13) + $signed(50'(ll_s2[k]));
			end
			last_s3 <= last_s2;
			// cross components
			n_s4[0] <= p_s3[0] - p_s3[1];
			n_s4[1] <= p_s3[2] - p_s3[3];
			n_s4[2] <= p_s3[4] - p_s3[5];
			last_s4 <= last_s3;
			// sign and magnitude
			for (int k = 0; k < 3; k++) begin
				mag_s5.neg[k] <= n_s4[k][49];
				mag_s5.m[k] <= n_s4[k][49] ? 49'(-n_s4[k]) : 49'(n_s4[k]);
			end
			mag_s5.last <= last_s4;
		end
	end

	assign v_out   = v_s5;
	assign mag_out = mag_s5;

endmodule

// File: hw/rtl/tfn_norm.sv
// leading one search and common shift of the three magnitudes
module tfn_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               v_in,
	input  tfn_pkg::tfn_mag_t  mag_in,
	output logic               v_out,
	output tfn_pkg::tfn_side_t side_out
);

	localparam int Chunks = 7;

	tfn_pkg::tfn_mag_t mag_s1, mag_s2;
	logic [Chunks-1:0] nz_s1;
	logic [2:0]        pos_s1 [Chunks];
	logic [5:0]        p_s2;
	logic              degen_s2;
	tfn_pkg::tfn_side_t side_s3;
	logic              v_s1, v_s2, v_s3;

	logic [55:0]       orv;
	logic [Chunks-1:0] nz_c;
	logic [2:0]        pos_c [Chunks];
	logic [5:0]        p_c;
	logic [77:0]       wide [3];

	// per chunk leading one
	always_comb begin
		orv = 56'(mag_in.m[0] | mag_in.m[1] | mag_in.m[2]);
		for (int c = 0; c < Chunks; c++) begin
			nz_c[c]  = |orv[8*c +: 8];
			pos_c[c] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (orv[8*c + b]) pos_c[c] = 3'(b);
			end
		end
	end

	// highest non-zero chunk
	always_comb begin
		p_c = 6'd0;
		for (int c = 0; c < Chunks; c++) begin
			if (nz_s1[c]) p_c = {3'(c), pos_s1[c]};
		end
	end

	// shift so the leading one lands on the top bit
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			wide[k] = {mag_s2.m[k], 29'd0} >> p_s2;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_in;
			nz_s1  <= nz_c;
			pos_s1 <= pos_c;
			mag_s2 <= mag_s1;
			p_s2   <= p_c;
			degen_s2 <= ~|nz_s1;
			for (int k = 0; k < 3; k++) side_s3.m[k] <= wide[k][tfn_pkg::NormW-1:0];
			side_s3.neg   <= mag_s2.neg;
			side_s3.degen <= degen_s2;
			side_s3.last  <= mag_s2.last;
		end
	end

	assign v_out    = v_s3;
	assign side_out = side_s3;

endmodule

// File: hw/rtl/tfn_sqrt.sv
// sum of squares and one root bit per stage
module tfn_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  tfn_pkg::tfn_side_t          side_in,
	output logic                        v_out,
	output tfn_pkg::tfn_side_t          side_out,
	output logic [tfn_pkg::RootW-1:0]   len_out
);

	localparam int Steps = tfn_pkg::RootW;

	logic [59:0]        sq_s1 [3];
	tfn_pkg::tfn_side_t side_s1;
	logic               v_s1;

	logic [62:0]        rem_s  [Steps+1];
	logic [62:0]        root_s [Steps+1];
	tfn_pkg::tfn_side_t side_s [Steps+1];
	logic               v_s    [Steps+1];

	// squares, then their sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in; v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) sq_s1[k] <= side_in.m[k] * side_in.m[k];
			side_s1 <= side_in;
			rem_s[0]  <= 63'(sq_s1[0]) + 63'(sq_s1[1]) + 63'(sq_s1[2]);
			root_s[0] <= 63'd0;
			side_s[0] <= side_s1;
		end
	end

	// restoring root, highest bit first
	for (genvar j = 0; j < Steps; j++) begin : g_root
		localparam logic [62:0] Bit = 63'(1) << (2 * (Steps - 1 - j));
		logic [62:0] trial;
		assign trial = root_s[j] + Bit;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j+1] <= 1'b0;
			else if (en) v_s[j+1] <= v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[j] >= trial) begin
					rem_s[j+1]  <= rem_s[j] - trial;
					root_s[j+1] <= (root_s[j] >> 1) + Bit;
				end else begin
					rem_s[j+1]  <= rem_s[j];
					root_s[j+1] <= root_s[j] >> 1;
				end
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign v_out    = v_s[Steps];
	assign side_out = side_s[Steps];
	assign len_out  = root_s[Steps][tfn_pkg::RootW-1:0];

endmodule

// File: hw/rtl/tfn_div.sv
// rounded quotient per component, one quotient bit per stage, and output format
module tfn_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      v_in,
	input  tfn_pkg::tfn_side_t        side_in,
	input  logic [tfn_pkg::RootW-1:0] len_in,
	output logic                      v_out,
	output tfn_pkg::tfn_nrm_t         nrm_out
);

	localparam int Steps = tfn_pkg::QuotW;

	logic [45:0]                   rem_s [3][Steps+1];
	logic [tfn_pkg::QuotW-1:0]     q_s   [3][Steps+1];
	logic [tfn_pkg::RootW-1:0]     len_s [Steps+1];
	tfn_pkg::tfn_side_t            side_s [Steps+1];
	logic                          v_s   [Steps+1];
	tfn_pkg::tfn_nrm_t             out_s;
	logic                          v_out_s;
	logic signed [tfn_pkg::OutW-1:0] comp [3];

	// numerator with half the divisor for rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s[0]  <= len_in;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_num
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k][0] <= {2'b00, side_in.m[k], 14'd0} + 46'(len_in >> 1);
				q_s[k][0]   <= '0;
			end
		end
	end

	// restoring division, highest quotient bit first
	for (genvar j = 0; j < Steps; j++) begin : g_div
		localparam int Sh = Steps - 1 - j;
		logic [45:0] dvs;
		assign dvs = 46'(len_s[j]) << Sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j+1] <= 1'b0;
			else if (en) v_s[j+1] <= v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[j+1]  <= len_s[j];
				side_s[j+1] <= side_s[j];
			end
		end

		for (genvar k = 0; k < 3; k++) begin : g_comp
			always_ff @(posedge clk) begin
				if (en) begin
					if (rem_s[k][j] >= dvs) begin
						rem_s[k][j+1] <= rem_s[k][j] - dvs;
						q_s[k][j+1]   <= q_s[k][j] | (tfn_pkg::QuotW'(1) << Sh);
					end else begin
						rem_s[k][j+1] <= rem_s[k][j];
						q_s[k][j+1]   <= q_s[k][j];
					end
				end
			end
		end
	end

	// apply sign, zero for a degenerate triangle
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (side_s[Steps].degen) comp[k] = '0;
			else if (side_s[Steps].neg[k]) comp[k] = -$signed({1'b0, q_s[k][Steps]});
			else comp[k] = $signed({1'b0, q_s[k][Steps]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out_s <= 1'b0;
		else if (en) v_out_s <= v_s[Steps];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s.nx <= comp[0];
			out_s.ny <= comp[1];
			out_s.nz <= comp[2];
			out_s.degenerate <= side_s[Steps].degen;
			out_s.last_out   <= side_s[Steps].last;
		end
	end

	assign v_out   = v_out_s;
	assign nrm_out = out_s;

endmodule

// File: hw/rtl/triangle_face_normal.sv
// top level: unit face normal of one triangle per item
//
//  channel    dir   payload
//  triangle   in    ax ay az bx by_coord bz cx cy cz last_in
//  normal     out   nx ny nz degenerate last_out
//
// one item enters per cycle while the output is not stalled; behind the split cross
// product each item passes the 31-stage square root and the 15-stage divider.
// reset clears the valid bits only.
// a stalled output holds the whole pipeline; nothing is dropped or repeated.
module triangle_face_normal (
	input  logic     clk,
	input  logic     arst_n,
	tfn_if.sink      triangle,
	tfn_if.source    normal
);

	logic                      en;
	logic                      v_mag, v_side, v_root;
	tfn_pkg::tfn_mag_t         mag;
	tfn_pkg::tfn_side_t        side, side_root;
	logic [tfn_pkg::RootW-1:0] len;
	tfn_pkg::tfn_tri_t         tri_data;
	tfn_pkg::tfn_nrm_t         nrm_data;

	// advance whenever the output register is free or being taken
	assign en = !normal.valid || normal.ready;
	assign triangle.ready = en;
	assign tri_data = triangle.data;
	assign normal.data = nrm_data;

	tfn_cross u_cross (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_in(triangle.valid), .tri_in(tri_data),
		.v_out(v_mag), .mag_out(mag)
	);

	tfn_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_in(v_mag), .mag_in(mag),
		.v_out(v_side), .side_out(side)
	);

	tfn_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_in(v_side), .side_in(side),
		.v_out(v_root), .side_out(side_root), .len_out(len)
	);

	tfn_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_in(v_root), .side_in(side_root), .len_in(len),
		.v_out(normal.valid), .nrm_out(nrm_data)
	);

endmodule
